// ===== rtl/jre_pkg.sv =====
package jre_pkg;

  localparam int DEFAULT_COUNT_BITS = 32;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [7:0] CHR_S      = 8'h53;
  localparam logic [7:0] CHR_O      = 8'h4F;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_U      = 8'h75;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] HIGH_START = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       direction;
    logic       first_of_record;
    logic       last_of_record;
    logic       empty_record;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [31:0] content_count;
  } out_word_t;

  // How the content byte of a job is written out.
  typedef enum logic [1:0] {
    BODY_NONE    = 2'd0,
    BODY_PLAIN   = 2'd1,
    BODY_SHORT   = 2'd2,
    BODY_UNICODE = 2'd3
  } body_kind_t;

  typedef struct packed {
    logic        prefix_en;
    logic [7:0]  prefix_char;
    body_kind_t  kind;
    logic [7:0]  data_byte;
    logic [7:0]  short_char;
    logic        suffix_en;
    logic [31:0] content_count;
  } job_t;

  function automatic body_kind_t byte_kind(input logic [7:0] c);
    body_kind_t k;
    if (c inside {8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09}) begin
      k = BODY_SHORT;
    end else if (c < CTRL_LIMIT || c >= HIGH_START) begin
      k = BODY_UNICODE;
    end else begin
      k = BODY_PLAIN;
    end
    return k;
  endfunction

  function automatic logic [7:0] short_escape(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      8'h08:   s = 8'h62;
      8'h0C:   s = 8'h66;
      8'h0A:   s = 8'h6E;
      8'h0D:   s = 8'h72;
      8'h09:   s = 8'h74;
      default: s = c;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = CHR_ZERO + {4'd0, n};
    end else begin
      d = 8'h57 + {4'd0, n};
    end
    return d;
  endfunction

endpackage

// ===== rtl/json_record_escaper.sv =====
// Frames byte records as JSON string lines: a direction letter, colon and quote, the escaped
// content, then quote and newline. One output word is one byte; the output port gives one
// byte per cycle while out_stall is low, and an input word becomes 1 to 11 output bytes:
// up to 6 for an escaped byte, 3 more with the prefix and 2 more with the suffix; plain
// mid-record bytes run at one per cycle unless stalled. Input words are taken back to back
// while the 4-entry job queue between the classifier and the byte sequencer has room. While
// paused, input words are taken and dropped without output.
module json_record_escaper import jre_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic paused;
  job_t push_job;
  job_t head_job;

  assign in_stall = q_full;

  jre_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .paused     (paused),
    .push       (q_push),
    .push_job   (push_job)
  );

  jre_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head_job(head_job)
  );

  jre_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head_job (head_job),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  // A paused block never queues a job.
  a_paused_drops: assert property (@(posedge clk) disable iff (!rst_n)
    paused |-> !q_push)
    else $error("job queued while paused");

  // Bytes of one run follow without a gap and share one count.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last_of_run |=>
      out_valid && out_word.content_count == $past(out_word.content_count))
    else $error("run broken or count changed within a run");

  // A job leaves the queue only while a byte is being produced for it.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/jre_front.sv =====
module jre_front import jre_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_word_t in_word,
  output logic     paused,
  output logic     push,
  output job_t     push_job
);

  logic                  paused_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  accept;

  assign accept    = in_valid && !in_stall;
  assign push      = accept && !paused_r;
  assign paused    = paused_r;
  assign count_inc = count_r + COUNT_BITS'(1);

  always_comb begin
    count_nxt = count_r;
    if (push && !in_word.empty_record) begin
      count_nxt = count_inc;
    end
  end

  always_comb begin
    push_job.prefix_char   = in_word.direction ? CHR_O : CHR_S;
    push_job.data_byte     = in_word.data_byte;
    push_job.short_char    = short_escape(in_word.data_byte);
    push_job.content_count = 32'(count_nxt);
    if (in_word.empty_record) begin
      push_job.prefix_en = 1'b1;
      push_job.kind      = BODY_NONE;
      push_job.suffix_en = 1'b1;
    end else begin
      push_job.prefix_en = in_word.first_of_record;
      push_job.kind      = byte_kind(in_word.data_byte);
      push_job.suffix_en = in_word.last_of_record;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        paused_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/jre_queue.sv =====
module jre_queue import jre_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head_job
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  assign full     = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign head_job = entries_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_step(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_step(rd_ptr_r);
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/jre_back.sv =====
module jre_back import jre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [3:0] pos_r;
  logic       out_valid_r;
  out_word_t  out_word_r;

  logic [3:0] p_len;
  logic [3:0] b_len;
  logic [3:0] s_len;
  logic [3:0] total;
  logic [3:0] body_off;
  logic [3:0] sfx_off;
  logic       last_byte;
  logic       advance;
  logic [7:0] cur_byte;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    p_len = head_job.prefix_en ? 4'd3 : 4'd0;
    s_len = head_job.suffix_en ? 4'd2 : 4'd0;
    case (head_job.kind)
      BODY_NONE:    b_len = 4'd0;
      BODY_PLAIN:   b_len = 4'd1;
      BODY_SHORT:   b_len = 4'd2;
      BODY_UNICODE: b_len = 4'd6;
      default:      b_len = 4'd0;
    endcase
    total     = p_len + b_len + s_len;
    body_off  = pos_r - p_len;
    sfx_off   = body_off - b_len;
    last_byte = (pos_r == total - 4'd1);
  end

  // The byte at the current position: prefix, then body, then suffix.
  always_comb begin
    if (pos_r < p_len) begin
      case (pos_r[1:0])
        2'd0:    cur_byte = head_job.prefix_char;
        2'd1:    cur_byte = CHR_COLON;
        default: cur_byte = CHR_QUOTE;
      endcase
    end else if (body_off < b_len) begin
      case (head_job.kind)
        BODY_PLAIN: cur_byte = head_job.data_byte;
        BODY_SHORT: cur_byte = (body_off == 4'd0) ? CHR_BSLASH : head_job.short_char;
        BODY_UNICODE: begin
          case (body_off[2:0])
            3'd0:    cur_byte = CHR_BSLASH;
            3'd1:    cur_byte = CHR_U;
            3'd2:    cur_byte = CHR_ZERO;
            3'd3:    cur_byte = CHR_ZERO;
            3'd4:    cur_byte = hex_digit(head_job.data_byte[7:4]);
            default: cur_byte = hex_digit(head_job.data_byte[3:0]);
          endcase
        end
        default: cur_byte = CHR_QUOTE;
      endcase
    end else begin
      cur_byte = (sfx_off == 4'd0) ? CHR_QUOTE : CHR_LF;
    end
  end

  assign advance = !out_valid_r || !out_stall;
  assign pop     = advance && !q_empty && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (advance) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        pos_r <= last_byte ? 4'd0 : pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      out_word_r.out_byte      <= cur_byte;
      out_word_r.last_of_run   <= last_byte;
      out_word_r.content_count <= head_job.content_count;
    end
  end

endmodule

// ===== test/json_record_escaper_tb.sv =====
`timescale 1ns / 1ps

module json_record_escaper_tb;
  import jre_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_LIMIT    = 3000;
  localparam int ACTIVE_WORDS  = 80;

  typedef struct {
    in_word_t    word;
    string       text;
    int unsigned count;
  } directed_row_t;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_word_t  in_word     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_word_t out_word;

  out_word_t     pending_text[$];
  directed_row_t directed_rows[$];
  logic [31:0]   content_total = '0;
  logic          paused_now    = 1'b0;
  string         hex_digits    = "0123456789abcdef";
  int            mismatches    = 0;
  int            idle_cycles   = 0;
  int            calm_words    = 0;
  int            active_words  = 0;

  json_record_escaper dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_word_t word_of(logic [7:0] data, logic dir, logic first,
                                       logic last, logic empty);
    in_word_t w;
    w.data_byte       = data;
    w.direction       = dir;
    w.first_of_record = first;
    w.last_of_record  = last;
    w.empty_record    = empty;
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Content bytes are biased toward the escaped classes.
  function automatic logic [7:0] pick_content();
    logic [7:0] shorts [7];
    int r;
    shorts = '{CHR_QUOTE, CHR_BSLASH, 8'h08, 8'h0C, CHR_LF, 8'h0D, 8'h09};
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return shorts[$urandom_range(0, 6)];
    end else if (r < 4) begin
      return 8'($urandom_range(0, 8'h1F));
    end else if (r < 6) begin
      return 8'($urandom_range(8'h80, 8'hFF));
    end
    return 8'($urandom_range(8'h20, 8'h7F));
  endfunction

  // Works out the text bytes that one input word turns into and advances the count.
  function automatic void frame_word(in_word_t w, ref out_word_t words[$]);
    logic [7:0] text[$];
    logic [7:0] c;
    logic [7:0] short_c;
    c = w.data_byte;
    if (paused_now) begin
      return;
    end
    if (w.empty_record || w.first_of_record) begin
      text.push_back(w.direction ? CHR_O : CHR_S);
      text.push_back(CHR_COLON);
      text.push_back(CHR_QUOTE);
    end
    if (!w.empty_record) begin
      case (c)
        CHR_QUOTE, CHR_BSLASH: short_c = c;
        8'h08:                 short_c = "b";
        8'h0C:                 short_c = "f";
        CHR_LF:                short_c = "n";
        8'h0D:                 short_c = "r";
        8'h09:                 short_c = "t";
        default:               short_c = 8'h00;
      endcase
      if (short_c != 8'h00) begin
        text.push_back(CHR_BSLASH);
        text.push_back(short_c);
      end else if (c < CTRL_LIMIT || c >= HIGH_START) begin
        text.push_back(CHR_BSLASH);
        text.push_back(CHR_U);
        text.push_back(CHR_ZERO);
        text.push_back(CHR_ZERO);
        text.push_back(hex_digits[c[7:4]]);
        text.push_back(hex_digits[c[3:0]]);
      end else begin
        text.push_back(c);
      end
      content_total = content_total + 32'd1;
    end
    if (w.empty_record || w.last_of_record) begin
      text.push_back(CHR_QUOTE);
      text.push_back(CHR_LF);
    end
    foreach (text[i]) begin
      words.push_back('{out_byte: text[i], last_of_run: (i == text.size() - 1),
                        content_count: content_total});
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // A non-empty text overrides the computed bytes; the count is still advanced.
  task automatic send_word(in_word_t w, string text, int unsigned count);
    out_word_t words[$];
    int gap;
    if (calm_words > 0) begin
      calm_words--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) begin
        calm_words = $urandom_range(20, 60);
      end
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!paused_now) begin
      active_words++;
    end
    frame_word(w, words);
    if (text.len() > 0) begin
      words.delete();
      for (int i = 0; i < text.len(); i++) begin
        words.push_back('{out_byte: text[i], last_of_run: (i == text.len() - 1),
                          content_count: count});
      end
    end
    foreach (words[i]) begin
      pending_text.push_back(words[i]);
    end
  endtask

  task automatic set_paused(logic value);
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    // A dropped word may still be in flight after the last byte has come out.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    paused_now = value;
  endtask

  // Mostly well-formed records with random content, the rest noise and broken framing.
  task automatic send_record();
    int kind;
    int len;
    logic dir;
    logic drop_first;
    logic drop_last;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_word(word_of(8'($urandom_range(0, 255)), logic'($urandom_range(0, 1)),
                        logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                        logic'($urandom_range(0, 1))), "", 0);
    end else if (kind < 20) begin
      send_word(word_of(8'($urandom_range(0, 255)), logic'($urandom_range(0, 1)),
                        logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), 1'b1),
                "", 0);
    end else begin
      len        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
      dir        = logic'($urandom_range(0, 1));
      drop_first = ($urandom_range(0, 19) == 0);
      drop_last  = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < len; i++) begin
        send_word(word_of(pick_content(), (i == 0) ? dir : logic'($urandom_range(0, 1)),
                          (i == 0) && !drop_first, (i == len - 1) && !drop_last, 1'b0),
                  "", 0);
      end
    end
  endtask

  always @(posedge clk) begin : stall_gen
    int stall_left;
    int calm_left;
    int r;
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        calm_left = $urandom_range(40, 150);
        out_stall <= 1'b0;
      end else if (r < 40) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_output
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h", out_word.out_byte));
      end else begin
        want = pending_text.pop_front();
        if (out_word.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %h, want %h", out_word.out_byte,
                                    want.out_byte));
        end
        if (out_word.last_of_run !== want.last_of_run) begin
          report_mismatch($sformatf("last_of_run %b, want %b on byte %h",
                                    out_word.last_of_run, want.last_of_run, want.out_byte));
        end
        if (out_word.content_count !== want.content_count) begin
          report_mismatch($sformatf("content_count %0d, want %0d",
                                    out_word.content_count, want.content_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("json_record_escaper verification failed");
      $finish;
    end
  end

  initial begin
    directed_rows.push_back('{word_of(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1), "S:\"\"\n", 0});
    directed_rows.push_back('{word_of(8'h41, 1'b1, 1'b1, 1'b1, 1'b1), "O:\"\"\n", 0});
    directed_rows.push_back('{word_of(8'h00, 1'b1, 1'b1, 1'b1, 1'b0),
                              "O:\"\\u0000\"\n", 1});
    directed_rows.push_back('{word_of(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0), "S:\"\\u00ff", 2});
    directed_rows.push_back('{word_of(CHR_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0), "\\\"", 3});
    directed_rows.push_back('{word_of(CHR_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0), "\\\\", 4});
    directed_rows.push_back('{word_of(8'h08, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h0C, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(CHR_LF, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h0D, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h09, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h1F, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h20, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h7F, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h80, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h7E, 1'b0, 1'b0, 1'b0, 1'b0), "", 0});
    // Direction on a word without a prefix has no effect.
    directed_rows.push_back('{word_of(8'h41, 1'b1, 1'b0, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h61, 1'b1, 1'b0, 1'b1, 1'b0), "", 0});
    // Framing flags are not tracked: a first after a first, a last without a first.
    directed_rows.push_back('{word_of(8'h30, 1'b1, 1'b1, 1'b0, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h31, 1'b0, 1'b1, 1'b1, 1'b0), "", 0});
    directed_rows.push_back('{word_of(8'h32, 1'b0, 1'b0, 1'b1, 1'b0), "", 0});
    directed_rows.push_back('{word_of(CHR_BSLASH, 1'b1, 1'b0, 1'b0, 1'b1), "", 0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_paused(1'b0);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].text, directed_rows[i].count);
    end

    for (int phase = 0; phase < 4; phase++) begin
      while (active_words < (phase + 1) * ACTIVE_WORDS / 4 + directed_rows.size()) begin
        send_record();
      end
      if (phase < 3) begin
        set_paused(1'b1);
        repeat ($urandom_range(3, 8)) send_record();
        set_paused(1'b0);
      end
    end

    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("json_record_escaper verification clean");
    end else begin
      $display("json_record_escaper verification failed");
    end
    $finish;
  end

endmodule
